/* src/content_crop_image_scaler_core_defines.svh */
// Assertion macros for the content crop image scaler core.
// No dependencies.
`ifndef CONTENT_CROP_IMAGE_SCALER_CORE_DEFINES_SVH
`define CONTENT_CROP_IMAGE_SCALER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CCIS_ASSERT_IMPL(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CCIS_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define CCIS_ASSERT_IMPL(label, a, c)
`define CCIS_ASSERT_NEXT(label, a, c)
`endif
`endif

/* src/ccis_pkg.sv */
// Shared constants for the content crop image scaler.
// No dependencies.
`timescale 1ns / 1ps
package ccis_pkg;
    localparam int SRC_MAX_WIDTH_DEF  = 128;
    localparam int SRC_MAX_HEIGHT_DEF = 128;
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_FETCH = 2'd2;
    localparam logic [2:0] REG_SRC_W  = 3'd0;
    localparam logic [2:0] REG_SRC_H  = 3'd1;
    localparam logic [2:0] REG_LEFT   = 3'd2;
    localparam logic [2:0] REG_TOP    = 3'd3;
    localparam logic [2:0] REG_DST_W  = 3'd4;
    localparam logic [2:0] REG_DST_H  = 3'd5;
    localparam logic [2:0] REG_TRANSP = 3'd6;
    localparam logic [2:0] REG_STRET  = 3'd7;
    localparam int DIV_W = 20;
endpackage

/* src/ccis_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on ccis_pkg.
`timescale 1ns / 1ps
module ccis_div import ccis_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [DIV_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    output logic             done,
    output logic [DIV_W-1:0] quo
);
    logic [DIV_W-1:0] q_reg;
    logic [DIV_W-1:0] r_reg;
    logic [DIV_W-1:0] d_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic [DIV_W:0]   trial;

    assign trial = {r_reg, q_reg[DIV_W-1]};
    assign quo = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so it fits DIV_W bits
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_reg <= DIV_W'(trial - {1'b0, d_reg});
                q_reg <= {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial[DIV_W-1:0];
                q_reg <= {q_reg[DIV_W-2:0], 1'b0};
            end
        end
    end
endmodule

/* src/ccis_store.sv */
// Frame store: single port synchronous RAM with registered read.
// Depends on ccis_pkg.
`timescale 1ns / 1ps
module ccis_store import ccis_pkg::*; #(
    parameter int DEPTH = SRC_MAX_WIDTH_DEF * SRC_MAX_HEIGHT_DEF,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);
    logic [31:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

/* src/content_crop_image_scaler_core.sv */
// Content crop image scaler top level: control, box tracking, fit, sampling.
// Depends on ccis_pkg, ccis_div, ccis_store and the defines header.
//
//  channel  signals                                   handshake
//  input    kind, pixel                               start & !busy
//  config   cfg_we, cfg_index, cfg_data               cfg_we
//  result   out_x, out_y, out_pixel, draw, last,      result_valid (one cycle)
//           status
// Start, load and unknown items are handled while idle; a fetch on an empty image
// answers in the cycle after its transfer. A pixel fetch keeps busy high through
// S_OUT, S_SX, S_SXW, S_SYW and S_RD, then its result follows: two divides (sx, sy)
// on the shared bit-serial divider. The first fetch of an image also passes S_CMP
// and, without stretch, the fit divide. A fetch past the end answers from S_OUT.
// Reset clears control; the store is not cleared. The result receiver cannot stall.
`timescale 1ns / 1ps
`include "content_crop_image_scaler_core_defines.svh"
module content_crop_image_scaler_core import ccis_pkg::*; #(
    parameter int SRC_MAX_WIDTH  = SRC_MAX_WIDTH_DEF,
    parameter int SRC_MAX_HEIGHT = SRC_MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] pixel,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    output logic        result_valid,
    output logic [10:0] out_x,
    output logic [10:0] out_y,
    output logic [31:0] out_pixel,
    output logic        draw,
    output logic        last,
    output logic        status
);
    localparam int DEPTH = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
    localparam int AW = $clog2(DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CMP  = 4'd1;
    localparam logic [3:0] S_F1   = 4'd2;
    localparam logic [3:0] S_F1W  = 4'd3;
    localparam logic [3:0] S_SX   = 4'd4;
    localparam logic [3:0] S_SXW  = 4'd5;
    localparam logic [3:0] S_SYW  = 4'd6;
    localparam logic [3:0] S_RD   = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [7:0] src_w_reg, src_h_reg;
    logic [9:0] left_reg, top_reg, dw_reg, dh_reg;
    logic       transp_reg, stretch_reg;

    logic [7:0]  load_col_reg, load_row_reg;
    logic [6:0]  bminx_reg, bmaxx_reg, bminy_reg, bmaxy_reg;
    logic        any_reg, fit_ready_reg;
    logic [10:0] fit_left_reg, fit_top_reg;
    logic [9:0]  fit_w_reg, fit_h_reg;
    logic [9:0]  ecol_reg, erow_reg;
    logic [3:0]  state_reg;
    logic        wide_reg;
    logic [19:0] sx_reg;

    logic [8:0] eff_w, eff_h;
    assign eff_w = (src_w_reg < 8'(SRC_MAX_WIDTH)) || (SRC_MAX_WIDTH > 255)
                   ? {1'b0, src_w_reg} : 9'(SRC_MAX_WIDTH);
    assign eff_h = (src_h_reg < 8'(SRC_MAX_HEIGHT)) || (SRC_MAX_HEIGHT > 255)
                   ? {1'b0, src_h_reg} : 9'(SRC_MAX_HEIGHT);

    logic [7:0] bw, bh;
    assign bw = {1'b0, bmaxx_reg - bminx_reg} + 8'd1;
    assign bh = {1'b0, bmaxy_reg - bminy_reg} + 8'd1;

    logic [17:0] prod_a, prod_b;
    assign prod_a = 18'(bh) * 18'(dw_reg);
    assign prod_b = 18'(bw) * 18'(dh_reg);

    // load path
    logic        acc;
    logic        ld_ok;
    logic [7:0]  lcol, lrow;
    logic        wrap;
    assign acc  = start && !busy;
    assign wrap = {1'b0, load_col_reg} >= eff_w;
    assign lcol = wrap ? 8'd0 : load_col_reg;
    assign lrow = wrap ? load_row_reg + 8'd1 : load_row_reg;
    assign ld_ok = acc && kind == KIND_LOAD && !fit_ready_reg && eff_w != 9'd0 &&
                   {1'b0, load_row_reg} < eff_h && {1'b0, lrow} < eff_h;

    // divider
    logic        dgo, ddone;
    logic [19:0] dnum, dden, dquo;
    ccis_div u_div (.clk(clk), .rst_n(rst_n), .go(dgo), .num(dnum), .den(dden),
                    .done(ddone), .quo(dquo));

    logic [AW-1:0] addr;
    logic [31:0]   rdata;
    logic [31:0]   sy_full;
    assign sy_full = 32'(dquo) + 32'(bminy_reg);
    assign addr = (state_reg == S_SYW)
                  ? AW'(sy_full * 32'(SRC_MAX_WIDTH) + 32'(sx_reg))
                  : AW'(32'(lrow) * 32'(SRC_MAX_WIDTH) + 32'(lcol));
    ccis_store #(.DEPTH(DEPTH), .AW(AW)) u_store (.clk(clk), .we(ld_ok), .addr(addr),
                    .wdata(pixel), .rdata(rdata));

    assign busy = state_reg != S_IDLE;

    always_comb
    begin
        dgo = 1'b0;
        dnum = '0;
        dden = 20'd1;
        case (state_reg)
            S_F1:
            begin
                dgo = 1'b1;
                if (wide_reg)
                begin
                    dnum = 20'(prod_b); dden = 20'(bh);
                end
                else
                begin
                    dnum = 20'(prod_a); dden = 20'(bw);
                end
            end
            S_SX:
            begin
                dgo = 1'b1;
                dnum = 20'(ecol_reg) * 20'(bw);
                dden = 20'(fit_w_reg);
            end
            S_SXW:
            begin
                dgo = ddone;
                dnum = 20'(erow_reg) * 20'(bh);
                dden = 20'(fit_h_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= '0; src_h_reg <= '0; left_reg <= '0; top_reg <= '0;
            dw_reg <= '0; dh_reg <= '0; transp_reg <= 1'b0; stretch_reg <= 1'b0;
            load_col_reg <= '0; load_row_reg <= '0;
            bminx_reg <= '1; bminy_reg <= '1; bmaxx_reg <= '0; bmaxy_reg <= '0;
            any_reg <= 1'b0; fit_ready_reg <= 1'b0;
            fit_left_reg <= '0; fit_top_reg <= '0; fit_w_reg <= '0; fit_h_reg <= '0;
            ecol_reg <= '0; erow_reg <= '0;
            state_reg <= S_IDLE; wide_reg <= 1'b0; sx_reg <= '0;
            result_valid <= 1'b0; out_x <= '0; out_y <= '0; out_pixel <= '0;
            draw <= 1'b0; last <= 1'b0; status <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SRC_W:  src_w_reg <= cfg_data[7:0];
                    REG_SRC_H:  src_h_reg <= cfg_data[7:0];
                    REG_LEFT:   left_reg <= cfg_data;
                    REG_TOP:    top_reg <= cfg_data;
                    REG_DST_W:  dw_reg <= cfg_data;
                    REG_DST_H:  dh_reg <= cfg_data;
                    REG_TRANSP: transp_reg <= cfg_data[0];
                    REG_STRET:  stretch_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (acc && kind == KIND_START)
                    begin
                        load_col_reg <= '0; load_row_reg <= '0;
                        bminx_reg <= '1; bminy_reg <= '1; bmaxx_reg <= '0; bmaxy_reg <= '0;
                        any_reg <= 1'b0; fit_ready_reg <= 1'b0;
                        fit_left_reg <= '0; fit_top_reg <= '0;
                        fit_w_reg <= '0; fit_h_reg <= '0;
                        ecol_reg <= '0; erow_reg <= '0;
                    end
                    else if (ld_ok)
                    begin
                        if (pixel != 32'd0)
                        begin
                            any_reg <= 1'b1;
                            if (lcol[6:0] < bminx_reg) bminx_reg <= lcol[6:0];
                            if (lcol[6:0] > bmaxx_reg) bmaxx_reg <= lcol[6:0];
                            if (lrow[6:0] < bminy_reg) bminy_reg <= lrow[6:0];
                            if (lrow[6:0] > bmaxy_reg) bmaxy_reg <= lrow[6:0];
                        end
                        if ({1'b0, lcol + 8'd1} >= eff_w)
                        begin
                            load_col_reg <= '0; load_row_reg <= lrow + 8'd1;
                        end
                        else
                        begin
                            load_col_reg <= lcol + 8'd1; load_row_reg <= lrow;
                        end
                    end
                    else if (acc && kind == KIND_LOAD && !fit_ready_reg && eff_w != 9'd0 &&
                             wrap && {1'b0, load_row_reg} < eff_h)
                    begin
                        load_col_reg <= '0; load_row_reg <= lrow;
                    end
                    else if (acc && kind == KIND_FETCH)
                    begin
                        if (!any_reg)
                        begin
                            result_valid <= 1'b1; status <= 1'b1; out_x <= '0; out_y <= '0;
                            out_pixel <= '0; draw <= 1'b0; last <= 1'b0;
                        end
                        else if (!fit_ready_reg)
                            state_reg <= S_CMP;
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_CMP:
                begin
                    fit_left_reg <= {1'b0, left_reg}; fit_top_reg <= {1'b0, top_reg};
                    fit_w_reg <= dw_reg; fit_h_reg <= dh_reg;
                    fit_ready_reg <= 1'b1; ecol_reg <= '0; erow_reg <= '0;
                    wide_reg <= prod_a > prod_b;
                    state_reg <= stretch_reg ? S_OUT : S_F1;
                end
                S_F1:
                    state_reg <= S_F1W;
                S_F1W:
                begin
                    if (ddone)
                    begin
                        if (wide_reg)
                        begin
                            fit_w_reg <= dquo[9:0];
                            fit_left_reg <= {1'b0, left_reg} +
                                            {1'b0, (dw_reg - dquo[9:0]) >> 1};
                        end
                        else
                        begin
                            fit_h_reg <= dquo[9:0];
                            fit_top_reg <= {1'b0, top_reg} +
                                           {1'b0, (dh_reg - dquo[9:0]) >> 1};
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (fit_w_reg == 10'd0 || fit_h_reg == 10'd0 || erow_reg >= fit_h_reg)
                    begin
                        result_valid <= 1'b1; status <= 1'b1; out_x <= '0; out_y <= '0;
                        out_pixel <= '0; draw <= 1'b0; last <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_SX;
                end
                S_SX:
                    state_reg <= S_SXW;
                S_SXW:
                begin
                    if (ddone)
                    begin
                        sx_reg <= dquo + 20'(bminx_reg);
                        state_reg <= S_SYW;
                    end
                end
                S_SYW:
                begin
                    if (ddone)
                        state_reg <= S_RD;
                end
                S_RD:
                begin
                    result_valid <= 1'b1; status <= 1'b0;
                    out_x <= fit_left_reg + {1'b0, ecol_reg};
                    out_y <= fit_top_reg + {1'b0, erow_reg};
                    out_pixel <= rdata;
                    draw <= !transp_reg || rdata != 32'd0;
                    last <= (ecol_reg + 10'd1 == fit_w_reg) && (erow_reg + 10'd1 == fit_h_reg);
                    if (ecol_reg + 10'd1 >= fit_w_reg)
                    begin
                        ecol_reg <= '0; erow_reg <= erow_reg + 10'd1;
                    end
                    else
                        ecol_reg <= ecol_reg + 10'd1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    `CCIS_ASSERT_IMPL(a_res_idle, result_valid, state_reg == S_IDLE)
    `CCIS_ASSERT_NEXT(a_rd_res, state_reg == S_RD, result_valid && !status)
    `CCIS_ASSERT_IMPL(a_no_load_busy, busy, !ld_ok)
endmodule
